// ===== rtl/core/imu_cal_pkg.sv =====
package imu_cal_pkg;

    // Command codes carried in each input item
    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_CAL_BOTH  = 2'd1;
    localparam logic [1:0] CMD_CAL_ACCEL = 2'd2;
    localparam logic [1:0] CMD_CAL_GYRO  = 2'd3;

    // Calibration phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_GYRO  = 2'd1;
    localparam logic [1:0] PH_ACCEL = 2'd2;

    // Fixed widths
    localparam int AXES     = 3;
    localparam int DATA_W   = 16;
    localparam int SUM_W    = 25;
    localparam int ONE_G_W  = 15;
    localparam int CNT_W    = 8;

    localparam logic [ONE_G_W-1:0] ONE_G_RST = 15'd8196;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } t_imu_in;

    typedef struct packed {
        logic signed [15:0] accel_x_fixed;
        logic signed [15:0] accel_y_fixed;
        logic signed [15:0] accel_z_fixed;
        logic signed [15:0] rate_x_fixed;
        logic signed [15:0] rate_y_fixed;
        logic signed [15:0] rate_z_fixed;
        logic [1:0]         cal_phase;
        logic               cal_done;
    } t_imu_out;

    // Per-item control from the sequencer to every axis lane
    typedef struct packed {
        logic acc_en;        // add this item's value into the sum
        logic acc_gyro;      // sum the gyro axis, else the accel axis
        logic clr_sum;       // clear the running sum
        logic clr_acc_off;   // clear the accel offset
        logic clr_rate_off;  // clear the gyro offset
        logic cap;           // final item: hand the sum to the divider
        logic wr_en;         // divider result ready: write an offset
        logic wr_gyro;       // divider result belongs to the gyro offset
    } t_lane_ctl;

endpackage

// ===== rtl/core/imu_bias_calibration_top.sv =====
// A sample item's result is registered and shows on the output in the cycle after it is accepted.
// Throughput: one item per cycle while the output register is free; the item that
// completes an offset average holds the input while each lane's reciprocal-multiply
// divider (multiply stage, then correction stage) writes the new offsets.
// Reset: synchronous, active low; clears offsets, sums, count and phase,
// and sets the one-g register to 8196.
module imu_bias_calibration_top #(
    parameter int SAMPLES = 200
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  imu_cal_pkg::t_imu_in                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output imu_cal_pkg::t_imu_out                o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [imu_cal_pkg::ONE_G_W-1:0]      i_cfg_data
);

    localparam int DW = imu_cal_pkg::DATA_W;
    localparam int CW = imu_cal_pkg::CNT_W;

    logic [1:0]                         r_phase;
    logic [1:0]                         n_phase;
    logic                               r_follows;
    logic                               n_follows;
    logic [CW-1:0]                      r_cnt;
    logic [CW-1:0]                      n_cnt;
    logic [imu_cal_pkg::ONE_G_W-1:0]    r_one_g;
    logic                               r_st1;
    logic                               r_st2;
    logic                               r_wr_gyro;
    logic                               r_out_valid;
    imu_cal_pkg::t_imu_out              r_out;

    logic                               w_busy;
    logic                               w_out_free;
    logic                               w_in_fire;
    logic                               w_sample;
    logic                               w_done;
    logic [CW:0]                        w_cnt_inc;
    logic                               w_last;
    imu_cal_pkg::t_lane_ctl             w_ctl;

    logic signed [DW-1:0]               w_acc_in  [imu_cal_pkg::AXES];
    logic signed [DW-1:0]               w_rate_in [imu_cal_pkg::AXES];
    logic signed [DW-1:0]               w_acc_fix [imu_cal_pkg::AXES];
    logic signed [DW-1:0]               w_rate_fix[imu_cal_pkg::AXES];
    logic [imu_cal_pkg::ONE_G_W-1:0]    w_bias    [imu_cal_pkg::AXES];

    // Handshakes
    assign w_busy      = r_st1 | r_st2;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_out_free && !w_busy;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_sample    = (i_in_data.command == imu_cal_pkg::CMD_SAMPLE);
    assign o_cfg_ready = 1'b1;

    assign w_cnt_inc = {1'b0, r_cnt} + (CW+1)'(1);
    assign w_last    = (w_cnt_inc >= (CW+1)'(SAMPLES));

    // Sequence calibration for each accepted item
    always_comb begin
        n_phase   = r_phase;
        n_follows = r_follows;
        n_cnt     = r_cnt;
        w_done    = 1'b0;
        w_ctl     = '0;
        w_ctl.acc_gyro = (r_phase == imu_cal_pkg::PH_GYRO);
        w_ctl.wr_en    = r_st2;
        w_ctl.wr_gyro  = r_wr_gyro;
        if (w_in_fire) begin
            case (i_in_data.command)
                imu_cal_pkg::CMD_SAMPLE: begin
                    if (r_phase == imu_cal_pkg::PH_GYRO ||
                        r_phase == imu_cal_pkg::PH_ACCEL) begin
                        w_ctl.acc_en = 1'b1;
                        n_cnt = w_cnt_inc[CW-1:0];
                        if (w_last) begin
                            w_done        = 1'b1;
                            w_ctl.cap     = 1'b1;
                            w_ctl.clr_sum = 1'b1;
                            n_cnt         = '0;
                            if (r_phase == imu_cal_pkg::PH_GYRO && r_follows) begin
                                n_follows         = 1'b0;
                                n_phase           = imu_cal_pkg::PH_ACCEL;
                                w_ctl.clr_acc_off = 1'b1;
                            end else begin
                                n_phase = imu_cal_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                imu_cal_pkg::CMD_CAL_ACCEL: begin
                    w_ctl.clr_sum     = 1'b1;
                    w_ctl.clr_acc_off = 1'b1;
                    n_cnt     = '0;
                    n_phase   = imu_cal_pkg::PH_ACCEL;
                    n_follows = 1'b0;
                end
                default: begin
                    w_ctl.clr_sum      = 1'b1;
                    w_ctl.clr_rate_off = 1'b1;
                    n_cnt     = '0;
                    n_phase   = imu_cal_pkg::PH_GYRO;
                    n_follows = (i_in_data.command == imu_cal_pkg::CMD_CAL_BOTH);
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= imu_cal_pkg::PH_IDLE;
            r_follows <= 1'b0;
            r_cnt     <= '0;
            r_one_g   <= imu_cal_pkg::ONE_G_RST;
            r_st1     <= 1'b0;
            r_st2     <= 1'b0;
            r_wr_gyro <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_follows <= n_follows;
            r_cnt     <= n_cnt;
            r_st1     <= w_done;
            r_st2     <= r_st1;
            if (w_done) begin
                r_wr_gyro <= w_ctl.acc_gyro;
            end
            if (i_cfg_valid) begin
                r_one_g <= i_cfg_data;
            end
        end
    end

    // Axis lanes
    assign w_acc_in[0]  = i_in_data.accel_x;
    assign w_acc_in[1]  = i_in_data.accel_y;
    assign w_acc_in[2]  = i_in_data.accel_z;
    assign w_rate_in[0] = i_in_data.rate_x;
    assign w_rate_in[1] = i_in_data.rate_y;
    assign w_rate_in[2] = i_in_data.rate_z;

    for (genvar g = 0; g < imu_cal_pkg::AXES; g++) begin : g_lane
        // Only the Z lane takes one g off
        assign w_bias[g] = (g == 2) ? r_one_g : '0;

        imu_cal_lane #(
            .SAMPLES (SAMPLES)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_accel       (w_acc_in[g]),
            .i_rate        (w_rate_in[g]),
            .i_bias        (w_bias[g]),
            .o_accel_fixed (w_acc_fix[g]),
            .o_rate_fixed  (w_rate_fix[g])
        );
    end

    // Merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && w_sample) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_sample) begin
            r_out.accel_x_fixed <= w_acc_fix[0];
            r_out.accel_y_fixed <= w_acc_fix[1];
            r_out.accel_z_fixed <= w_acc_fix[2];
            r_out.rate_x_fixed  <= w_rate_fix[0];
            r_out.rate_y_fixed  <= w_rate_fix[1];
            r_out.rate_z_fixed  <= w_rate_fix[2];
            r_out.cal_phase     <= n_phase;
            r_out.cal_done      <= w_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/imu_cal_lane.sv =====
module imu_cal_lane #(
    parameter int SAMPLES = 200
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  imu_cal_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [imu_cal_pkg::DATA_W-1:0]  i_accel,
    input  logic signed [imu_cal_pkg::DATA_W-1:0]  i_rate,
    input  logic [imu_cal_pkg::ONE_G_W-1:0]        i_bias,
    output logic signed [imu_cal_pkg::DATA_W-1:0]  o_accel_fixed,
    output logic signed [imu_cal_pkg::DATA_W-1:0]  o_rate_fixed
);

    // Reciprocal of the sample count, scaled by 2^32
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / SAMPLES;
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [7:0]  DIVISOR    = 8'(SAMPLES);

    localparam int SW = imu_cal_pkg::SUM_W;
    localparam int DW = imu_cal_pkg::DATA_W;

    logic signed [DW-1:0] r_acc_off;
    logic signed [DW-1:0] r_rate_off;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] r_cap;
    logic [SW-1:0]        r_mag;
    logic [SW-1:0]        r_q0;
    logic                 r_neg;

    logic signed [DW-1:0] w_acc_fix;
    logic signed [DW-1:0] w_rate_fix;
    logic signed [SW-1:0] w_v;
    logic signed [SW-1:0] w_sum_next;
    logic [SW-1:0]        w_abs;
    logic [SW+31:0]       w_prod;
    logic [SW+7:0]        w_qs;
    logic [SW-1:0]        w_rem;
    logic [SW-1:0]        w_q;
    logic [SW-1:0]        w_avg;
    logic [DW-1:0]        w_off;

    // Remove the stored offsets, wrapping to 16 bits
    assign w_acc_fix  = i_accel - r_acc_off;
    assign w_rate_fix = i_rate - r_rate_off;
    assign o_accel_fixed = w_acc_fix;
    assign o_rate_fixed  = w_rate_fix;

    // Select the value to sum; accel takes the bias off
    always_comb begin
        if (i_ctl.acc_gyro) begin
            w_v = SW'(w_rate_fix);
        end else begin
            w_v = SW'(w_acc_fix) - $signed({{(SW-imu_cal_pkg::ONE_G_W){1'b0}}, i_bias});
        end
    end

    assign w_sum_next = r_sum + w_v;

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clr_sum) begin
            r_sum <= '0;
        end else if (i_ctl.acc_en) begin
            r_sum <= w_sum_next;
        end
    end

    // Divider stage 0: hold the final sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cap <= w_sum_next;
        end
    end

    // Divider stage 1: magnitude times reciprocal
    assign w_abs  = r_cap[SW-1] ? SW'(-r_cap) : SW'(r_cap);
    assign w_prod = {32'd0, w_abs} * {{SW{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        r_q0  <= w_prod[SW+31:32];
        r_mag <= w_abs;
        r_neg <= r_cap[SW-1];
    end

    // Divider stage 2: correct the estimate by one and restore the sign
    assign w_qs  = {8'd0, r_q0} * {{SW{1'b0}}, DIVISOR};
    assign w_rem = r_mag - w_qs[SW-1:0];
    assign w_q   = (w_rem >= SW'(DIVISOR)) ? r_q0 + SW'(1) : r_q0;
    assign w_avg = r_neg ? -w_q : w_q;
    assign w_off = w_avg[DW-1:0];

    // Offset store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_off  <= '0;
            r_rate_off <= '0;
        end else begin
            if (i_ctl.clr_acc_off) begin
                r_acc_off <= '0;
            end else if (i_ctl.wr_en && !i_ctl.wr_gyro) begin
                r_acc_off <= w_off;
            end
            if (i_ctl.clr_rate_off) begin
                r_rate_off <= '0;
            end else if (i_ctl.wr_en && i_ctl.wr_gyro) begin
                r_rate_off <= w_off;
            end
        end
    end

endmodule

// ===== rtl/core/imu_cal_chk.sv =====
module imu_cal_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input imu_cal_pkg::t_imu_in  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input imu_cal_pkg::t_imu_out o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A sample item always yields a result next cycle
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == imu_cal_pkg::CMD_SAMPLE
        |=> o_out_valid)
        else $error("sample item gave no result");

    // A start command into an empty output gives no result
    a_cmd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid && o_in_ready &&
        i_in_data.command != imu_cal_pkg::CMD_SAMPLE
        |=> !o_out_valid)
        else $error("start command gave a result");

    // Hold the input while new offsets are computed
    a_done_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.command == imu_cal_pkg::CMD_SAMPLE)
        ##1 o_out_data.cal_done |-> !o_in_ready)
        else $error("input taken while offsets update");

    // Phase reports only defined codes
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cal_phase == imu_cal_pkg::PH_IDLE ||
                         o_out_data.cal_phase == imu_cal_pkg::PH_GYRO ||
                         o_out_data.cal_phase == imu_cal_pkg::PH_ACCEL))
        else $error("undefined phase reported");

endmodule

bind imu_bias_calibration_top imu_cal_chk u_imu_cal_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== dv/imu_bias_calibration_top_tb.sv =====
module imu_bias_calibration_top_tb;
    import imu_cal_pkg::*;

    localparam int CAL_SAMPLES   = 200;
    localparam int ITEMS_TARGET  = 1300;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int IDLE_PCT      = 27;

    // Ways of filling the six axes of a sample
    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_NOISY   = 1;
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_FLOOR   = 3;
    localparam int STYLE_EXACT   = 4;

    // Predicts every sample result and checks the block against it
    class cal_scoreboard;
        logic signed [15:0] accel_off [3];
        logic signed [15:0] rate_off [3];
        int                 axis_sum [3];
        int                 n_summed;
        logic [1:0]         phase;
        bit                 accel_next;
        logic [14:0]        one_g;
        int                 avg_len;
        t_imu_out           expected_q [$];
        int                 results_seen;
        int                 errors;

        function new(int n_avg);
            avg_len = n_avg;
            foreach (accel_off[i]) begin
                accel_off[i] = '0;
                rate_off[i]  = '0;
            end
            clear_sums();
            phase        = PH_IDLE;
            accel_next   = 1'b0;
            one_g        = ONE_G_RST;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void clear_sums();
            foreach (axis_sum[i]) axis_sum[i] = 0;
            n_summed = 0;
        endfunction

        function void set_one_g(logic [14:0] v);
            one_g = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the calibration state by one accepted item
        function void note_input(t_imu_in it);
            logic signed [15:0] raw_a [3];
            logic signed [15:0] raw_r [3];
            logic signed [15:0] fa [3];
            logic signed [15:0] fr [3];
            t_imu_out           want;
            bit                 gyro;
            bit                 done;
            int                 v;

            // Start command: abort, clear the sensor's offsets, no result
            if (it.command != CMD_SAMPLE) begin
                clear_sums();
                if (it.command == CMD_CAL_ACCEL) begin
                    phase      = PH_ACCEL;
                    accel_next = 1'b0;
                    foreach (accel_off[i]) accel_off[i] = '0;
                end else begin
                    phase      = PH_GYRO;
                    accel_next = (it.command == CMD_CAL_BOTH);
                    foreach (rate_off[i]) rate_off[i] = '0;
                end
                return;
            end

            raw_a = '{it.accel_x, it.accel_y, it.accel_z};
            raw_r = '{it.rate_x, it.rate_y, it.rate_z};
            for (int i = 0; i < 3; i++) begin
                fa[i] = raw_a[i] - accel_off[i];
                fr[i] = raw_r[i] - rate_off[i];
            end

            // Accumulate while calibrating; store the average on the last sample
            done = 1'b0;
            if (phase != PH_IDLE) begin
                gyro = (phase == PH_GYRO);
                for (int i = 0; i < 3; i++) begin
                    v = gyro ? int'(fr[i]) : int'(fa[i]);
                    if (!gyro && i == 2)
                        v = v - int'({1'b0, one_g});
                    axis_sum[i] += v;
                end
                n_summed++;
                if (n_summed >= avg_len) begin
                    done = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        if (gyro)
                            rate_off[i] = 16'(axis_sum[i] / avg_len);
                        else
                            accel_off[i] = 16'(axis_sum[i] / avg_len);
                    end
                    clear_sums();
                    if (gyro && accel_next) begin
                        accel_next = 1'b0;
                        phase      = PH_ACCEL;
                        foreach (accel_off[i]) accel_off[i] = '0;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            end

            want.accel_x_fixed = fa[0];
            want.accel_y_fixed = fa[1];
            want.accel_z_fixed = fa[2];
            want.rate_x_fixed  = fr[0];
            want.rate_y_fixed  = fr[1];
            want.rate_z_fixed  = fr[2];
            want.cal_phase     = phase;
            want.cal_done      = done;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          results_seen, name, got, want));
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(t_imu_out got);
            t_imu_out want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no sample waiting");
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            check_field("accel_x_fixed", got.accel_x_fixed, want.accel_x_fixed);
            check_field("accel_y_fixed", got.accel_y_fixed, want.accel_y_fixed);
            check_field("accel_z_fixed", got.accel_z_fixed, want.accel_z_fixed);
            check_field("rate_x_fixed", got.rate_x_fixed, want.rate_x_fixed);
            check_field("rate_y_fixed", got.rate_y_fixed, want.rate_y_fixed);
            check_field("rate_z_fixed", got.rate_z_fixed, want.rate_z_fixed);
            check_field("cal_phase", {1'b0, got.cal_phase}, {1'b0, want.cal_phase});
            check_field("cal_done", {1'b0, got.cal_done}, {1'b0, want.cal_done});
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_imu_in              i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_imu_out             o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ONE_G_W-1:0]   i_cfg_data = ONE_G_RST;

    cal_scoreboard        sb = new(CAL_SAMPLES);
    bit                   steady = 1'b0;
    int                   items_sent = 0;
    int                   cycles = 0;

    imu_bias_calibration_top #(
        .SAMPLES(CAL_SAMPLES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random, except in a steady stretch
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // End the run if it hangs
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** imu_bias_calibration_top: FAILED **");
        $finish;
    end

    function automatic logic [15:0] pick_value(int style, logic [15:0] bias);
        case (style)
            STYLE_NOISY:   return bias + 16'($urandom_range(128)) - 16'd64;
            STYLE_EXACT:   return bias;
            STYLE_FLOOR:   return 16'h8000;
            STYLE_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default:       return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_in make_item(logic [1:0] cmd, int style, logic [5:0][15:0] bias);
        t_imu_in it;
        it.command = cmd;
        it.accel_x = pick_value(style, bias[0]);
        it.accel_y = pick_value(style, bias[1]);
        it.accel_z = pick_value(style, bias[2]);
        it.rate_x  = pick_value(style, bias[3]);
        it.rate_y  = pick_value(style, bias[4]);
        it.rate_z  = pick_value(style, bias[5]);
        return it;
    endfunction

    // Offer one item, with random gaps, and hold it until accepted
    task automatic send_item(t_imu_in it);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_start(logic [1:0] cmd);
        send_item(make_item(cmd, STYLE_RANDOM, '0));
    endtask

    // Send a run of samples; the noisy and exact styles sit around one random bias per axis
    task automatic send_samples(int n, int style);
        logic [5:0][15:0] bias;
        bias = {$urandom, $urandom, $urandom};
        for (int k = 0; k < n; k++)
            send_item(make_item(CMD_SAMPLE, style, bias));
    endtask

    // Drop valid and wait until every expected result is in, then settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_one_g(logic [ONE_G_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_one_g(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [1:0] cmd;
        int         full_len;
        int         n;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes while idle
        send_item(make_item(CMD_SAMPLE, STYLE_EXACT, '0));
        send_item(make_item(CMD_SAMPLE, STYLE_FLOOR, '0));
        send_item(make_item(CMD_SAMPLE, STYLE_EXACT, {6{16'h7FFF}}));
        send_item(make_item(CMD_SAMPLE, STYLE_EXACT, {3{16'h5555, 16'hAAAA}}));
        send_item(make_item(CMD_SAMPLE, STYLE_EXTREME, '0));
        // Directed: each start command, aborts and back-to-back starts
        send_start(CMD_CAL_GYRO);
        send_samples(3, STYLE_EXTREME);
        send_start(CMD_CAL_ACCEL);
        send_samples(3, STYLE_EXTREME);
        send_start(CMD_CAL_BOTH);
        send_samples(3, STYLE_EXTREME);
        send_start(CMD_CAL_GYRO);
        send_start(CMD_CAL_ACCEL);
        send_samples(2, STYLE_RANDOM);
        drain();

        // Gyro then accel at the floor with the largest one-g: accel Z average wraps
        write_one_g(15'h7FFF);
        send_start(CMD_CAL_BOTH);
        send_samples(2 * CAL_SAMPLES, STYLE_FLOOR);
        send_samples(10, STYLE_EXTREME);
        drain();

        // Gyro alone on full-range data, one-g of zero, no idling on either side
        steady = 1'b1;
        write_one_g('0);
        send_start(CMD_CAL_GYRO);
        send_samples(CAL_SAMPLES, STYLE_RANDOM);
        send_samples(10, STYLE_RANDOM);
        drain();
        steady = 1'b0;

        // Accel alone near a fixed bias, reset one-g
        write_one_g(ONE_G_RST);
        send_start(CMD_CAL_ACCEL);
        send_samples(CAL_SAMPLES, STYLE_NOISY);
        send_samples(10, STYLE_RANDOM);
        drain();

        // Random calibrations, some cut short by a new start
        while (items_sent < ITEMS_TARGET) begin
            case ($urandom_range(3))
                0:       write_one_g('0);
                1:       write_one_g(15'h7FFF);
                default: write_one_g(15'($urandom));
            endcase
            if ($urandom_range(5) == 0)
                send_start(2'($urandom_range(CMD_CAL_BOTH, CMD_CAL_GYRO)));
            cmd      = 2'($urandom_range(CMD_CAL_BOTH, CMD_CAL_GYRO));
            full_len = (cmd == CMD_CAL_BOTH) ? 2 * CAL_SAMPLES : CAL_SAMPLES;
            n        = ($urandom_range(3) == 0) ? $urandom_range(1, full_len - 1) : full_len;
            send_start(cmd);
            send_samples(n, $urandom_range(STYLE_RANDOM, STYLE_EXTREME));
            send_samples($urandom_range(0, 12), STYLE_RANDOM);
            drain();
        end

        if (sb.errors == 0)
            $display("** imu_bias_calibration_top: PASSED **");
        else
            $display("** imu_bias_calibration_top: FAILED **");
        $finish;
    end

endmodule
